// ===== sv/vn_pkg.sv =====
// shared constants and types for the vector normalizer
package vn_pkg;

   localparam int CompWidth  = 32;
   localparam int MagWidth   = 32;
   localparam int SumWidth   = 64;
   localparam int RootWidth  = 32;
   localparam int FracBits   = 16;
   localparam int DividendWidth = MagWidth + FracBits;
   localparam int QuotWidth  = 17;
   localparam int RootSteps  = RootWidth;
   localparam int DivSteps   = QuotWidth;
   localparam int Lanes      = 3;
   localparam int TdataWidth = Lanes * CompWidth;
   localparam logic [31:0] TinyLimitReset = 32'd4295;

   typedef logic [MagWidth-1:0] mag_type;
   typedef logic [SumWidth-1:0] sum_type;
   typedef logic [RootWidth-1:0] root_type;

   // per-item side data that rides the pipeline
   typedef struct packed {
      logic [Lanes-1:0]                neg;
      logic [Lanes-1:0][MagWidth-1:0]  mag;
      logic [Lanes-1:0][CompWidth-1:0] raw;
      logic                            tiny;
   } side_type;

endpackage

// ===== sv/vector3_normalizer.sv =====
// vector3_normalizer: unit-length scaling of a 3d fixed-point vector
//
// input item on req_tdata: x_in, y_in, z_in (32 bits each, 16 fraction bits)
// result item on rsp_tdata: x_out, y_out, z_out, too_small flag on rsp_tuser
// csr_wr_en/csr_wr_data write the squared-magnitude limit (32 fraction bits)
// items at or above the limit are divided by the floor square root of the
// sum of squares; items below pass unchanged with too_small set
// pipeline: 1 + 1 + 32 + 17 + 1 = 52 register stages
// throughput: one item per cycle unless the receiver stalls; every step
// of the root and of the three restoring dividers is its own register stage
// reset clears all stage valid bits and loads the limit with 4295
// when the receiver stalls with the output full, the whole pipeline
// holds; req_tready falls only when the output register is full and stalled
module vector3_normalizer (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [95:0] req_tdata,  // x_in[31:0], y_in[63:32], z_in[95:64]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [95:0] rsp_tdata,  // x_out[31:0], y_out[63:32], z_out[95:64]
   output logic        rsp_tuser   // too_small
);

   localparam int L = vn_pkg::Lanes;
   localparam int MW = vn_pkg::MagWidth;
   localparam int RW = vn_pkg::RootWidth;
   localparam int SW = vn_pkg::SumWidth;
   localparam int DW = vn_pkg::DividendWidth;
   localparam int RS = vn_pkg::RootSteps;
   localparam int DS = vn_pkg::DivSteps;
   localparam int CW = vn_pkg::CompWidth;

   logic advance;
   logic [31:0] limit_ff;

   // limit register
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= vn_pkg::TinyLimitReset;
      end else if (csr_wr_en) begin
         limit_ff <= csr_wr_data;
      end
   end

   // stage a: magnitudes and squares
   logic a_v_ff;
   vn_pkg::side_type a_side_ff, a_side_in;
   logic [L-1:0][63:0] a_sq_ff, a_sq_in;

   always_comb begin
      a_side_in = '0;
      for (int i = 0; i < L; i++) begin
         a_side_in.raw[i] = req_tdata[i*CW +: CW];
         a_side_in.neg[i] = req_tdata[i*CW + CW - 1];
         a_side_in.mag[i] = a_side_in.neg[i] ? (MW'(0) - req_tdata[i*CW +: CW])
                                             : req_tdata[i*CW +: CW];
         a_sq_in[i] = 64'(a_side_in.mag[i]) * 64'(a_side_in.mag[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) a_v_ff <= 1'b0;
      else if (advance) a_v_ff <= req_tvalid;
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         a_side_ff <= a_side_in;
         a_sq_ff   <= a_sq_in;
      end
   end

   // stage b: sum of squares and limit compare
   logic b_v_ff;
   vn_pkg::side_type b_side_ff, b_side_in;
   vn_pkg::sum_type b_sum_ff, b_sum_in;

   always_comb begin
      b_sum_in = a_sq_ff[0] + a_sq_ff[1] + a_sq_ff[2];
      b_side_in = a_side_ff;
      b_side_in.tiny = b_sum_in < SW'(limit_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) b_v_ff <= 1'b0;
      else if (advance) b_v_ff <= a_v_ff;
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         b_side_ff <= b_side_in;
         b_sum_ff  <= b_sum_in;
      end
   end

   // square root: one result bit per stage, restoring
   logic [RS:1] r_v_ff;
   vn_pkg::side_type r_side_ff [1:RS];
   logic [SW-1:0] r_rem_ff [1:RS];
   logic [RW-1:0] r_root_ff [1:RS];

   for (genvar s = 0; s < RS; s++) begin : g_root
      localparam int Bit = RS - 1 - s;
      logic v_prev;
      vn_pkg::side_type side_prev;
      logic [SW-1:0] rem_prev;
      logic [RW-1:0] root_prev;
      logic [SW+1:0] trial;
      logic [SW+1:0] sub;
      logic [RW-1:0] root_in;
      logic [SW-1:0] rem_in;
      // stage source: the sum stage or the previous root step
      if (s == 0) begin : g_first
         assign v_prev    = b_v_ff;
         assign side_prev = b_side_ff;
         assign rem_prev  = b_sum_ff;
         assign root_prev = '0;
      end else begin : g_next
         assign v_prev    = r_v_ff[s];
         assign side_prev = r_side_ff[s];
         assign rem_prev  = r_rem_ff[s];
         assign root_prev = r_root_ff[s];
      end
      always_comb begin
         // trial = (2*root*2^bit + 2^(2bit)) compared with remainder
         trial = ((SW+2)'(root_prev) << (Bit + 1)) + ((SW+2)'(1) << (2 * Bit));
         sub = (SW+2)'(rem_prev) - trial;
         if ((SW+2)'(rem_prev) >= trial) begin
            rem_in  = sub[SW-1:0];
            root_in = root_prev | (RW'(1) << Bit);
         end else begin
            rem_in  = rem_prev;
            root_in = root_prev;
         end
      end
      always_ff @(posedge clock) begin
         if (reset) r_v_ff[s+1] <= 1'b0;
         else if (advance) r_v_ff[s+1] <= v_prev;
      end
      always_ff @(posedge clock) begin
         if (advance) begin
            r_side_ff[s+1] <= side_prev;
            r_rem_ff[s+1]  <= rem_in;
            r_root_ff[s+1] <= root_in;
         end
      end
   end

   // division: three restoring lanes, one quotient bit per stage
   logic [DS:1] d_v_ff;
   vn_pkg::side_type d_side_ff [1:DS];
   logic [RW-1:0] d_root_ff [1:DS];
   logic [L-1:0][DW-1:0] d_rem_ff [1:DS];
   logic [L-1:0][DS-1:0] d_q_ff [1:DS];

   for (genvar s = 0; s < DS; s++) begin : g_div
      localparam int Bit = DS - 1 - s;
      logic v_prev;
      vn_pkg::side_type side_prev;
      logic [RW-1:0] root_prev;
      logic [L-1:0][DW-1:0] rem_prev;
      logic [L-1:0][DS-1:0] q_prev;
      logic [L-1:0][DW-1:0] rem_in;
      logic [L-1:0][DS-1:0] q_in;
      logic [DW+DS-1:0] den;
      // stage source: the last root step or the previous divide step
      if (s == 0) begin : g_first
         assign v_prev    = r_v_ff[RS];
         assign side_prev = r_side_ff[RS];
         assign root_prev = r_root_ff[RS];
         assign q_prev    = '0;
         always_comb begin
            for (int i = 0; i < L; i++) begin
               rem_prev[i] = {r_side_ff[RS].mag[i], 16'h0};
            end
         end
      end else begin : g_next
         assign v_prev    = d_v_ff[s];
         assign side_prev = d_side_ff[s];
         assign root_prev = d_root_ff[s];
         assign rem_prev  = d_rem_ff[s];
         assign q_prev    = d_q_ff[s];
      end
      always_comb begin
         den = (DW+DS)'(root_prev) << Bit;
         for (int i = 0; i < L; i++) begin
            if ((DW+DS)'(rem_prev[i]) >= den && root_prev != '0) begin
               rem_in[i] = rem_prev[i] - den[DW-1:0];
               q_in[i]   = q_prev[i] | (DS'(1) << Bit);
            end else begin
               rem_in[i] = rem_prev[i];
               q_in[i]   = q_prev[i];
            end
         end
      end
      always_ff @(posedge clock) begin
         if (reset) d_v_ff[s+1] <= 1'b0;
         else if (advance) d_v_ff[s+1] <= v_prev;
      end
      always_ff @(posedge clock) begin
         if (advance) begin
            d_side_ff[s+1] <= side_prev;
            d_root_ff[s+1] <= root_prev;
            d_rem_ff[s+1]  <= rem_in;
            d_q_ff[s+1]    <= q_in;
         end
      end
   end

   // output register: sign, pass-through select
   logic o_v_ff;
   logic [95:0] o_data_ff, o_data_in;
   logic o_small_ff;

   always_comb begin
      for (int i = 0; i < L; i++) begin
         if (d_side_ff[DS].tiny) begin
            o_data_in[i*CW +: CW] = d_side_ff[DS].raw[i];
         end else if (d_side_ff[DS].neg[i]) begin
            o_data_in[i*CW +: CW] = CW'(0) - CW'(d_q_ff[DS][i]);
         end else begin
            o_data_in[i*CW +: CW] = CW'(d_q_ff[DS][i]);
         end
      end
   end

   assign advance = !o_v_ff || rsp_tready;
   assign req_tready = advance;

   always_ff @(posedge clock) begin
      if (reset) o_v_ff <= 1'b0;
      else if (advance) o_v_ff <= d_v_ff[DS];
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         o_data_ff  <= o_data_in;
         o_small_ff <= d_side_ff[DS].tiny;
      end
   end

   assign rsp_tvalid = o_v_ff;
   assign rsp_tdata  = o_data_ff;
   assign rsp_tuser  = o_small_ff;

   // a stalled result holds its data
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // input is refused only while the output is full and stalled
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("input stalled without cause");

   // root must never exceed the square root of the sum
   assert property (@(posedge clock) disable iff (reset)
      r_v_ff[RS] |-> (SW'(r_root_ff[RS]) * SW'(r_root_ff[RS])) <= {r_rem_ff[RS]} +
         (SW'(r_root_ff[RS]) * SW'(r_root_ff[RS])))
      else $error("root overflow");

endmodule
